// ===== src/dtp_pkg.sv =====
// ---------------------------------------------------------------------------
// dtp_pkg: shared definitions for the DNA triple packer
// Symbol codes, the letter-to-code table and the group type that the
// top level and the byte encoder both use.
// ---------------------------------------------------------------------------
package dtp_pkg;

  localparam int SYMBOL_W       = 8;
  localparam int CODE_W         = 3;
  localparam int BYTE_W         = 8;
  localparam int OUT_COUNT_W    = 32;
  localparam int COUNT_BITS_DEF = 32;
  localparam int TABLE_DEPTH    = 20;
  localparam int TABLE_IDX_W    = $clog2(TABLE_DEPTH);

  typedef logic [CODE_W-1:0] code_t;
  // Group of three collapsed symbols, element 0 is the oldest one.
  typedef code_t [2:0] group_t;

  localparam code_t CODE_A = 3'd0;
  localparam code_t CODE_N = 3'd4;

  localparam logic [SYMBOL_W-1:0] LETTER_FIRST = 8'h41;  // 'A'
  localparam logic [SYMBOL_W-1:0] LETTER_LAST  = 8'h54;  // 'T'

  // Codes for 'A' through 'T'; C, G, T and N carry their own code.
  localparam code_t LETTER_CODE [TABLE_DEPTH] = '{
    3'd0, 3'd0, 3'd1, 3'd0, 3'd0, 3'd0, 3'd2, 3'd0, 3'd0, 3'd0,
    3'd0, 3'd0, 3'd0, 3'd4, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd3
  };

  // Bits 1:0 of a packed byte hold how many Ns the group carries.
  localparam logic [1:0] N_NONE = 2'd0;
  localparam logic [1:0] N_ONE  = 2'd1;
  localparam logic [1:0] N_TWO  = 2'd2;
  localparam logic [1:0] N_THREE = 2'd3;

endpackage

// ===== src/dna_triple_packer.sv =====
// ---------------------------------------------------------------------------
// dna_triple_packer: streaming 2-bit nucleotide packer
// Collapses runs of N, maps nucleotides to 2-bit codes and packs three
// collapsed symbols into one byte, with a symbol count on every result.
// ---------------------------------------------------------------------------
//
//  Channel | Direction | tdata (low bit up)                      | side bands
//  --------+-----------+-----------------------------------------+---------------------------
//  s_*     | in        | [7:0] symbol                            | tlast = final_symbol
//  m_*     | out       | [7:0] packed_byte, [39:8] symbol_count  | tuser = byte_present,
//          |           |                                         | tlast = sequence_end
//
// One symbol is taken per cycle. The whole update (map, collapse, group and
// pack) is done in one pass from the input port into the output register,
// so a result appears in the cycle after the transaction that causes it.
// A new transaction is taken whenever the output register is empty or is
// being emptied in the same cycle; while a result waits with m_tready low,
// s_tready stays low for as long as the output stall lasts. rst is
// synchronous and clears the sequence state and the output valid flag.
//
module dna_triple_packer
  import dtp_pkg::*;
#(
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic [SYMBOL_W-1:0]          s_tdata,   // [7:0] symbol
  input  logic                         s_tlast,   // final_symbol
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic [BYTE_W+OUT_COUNT_W-1:0] m_tdata,  // [7:0] packed_byte, [39:8] symbol_count
  output logic                         m_tuser,   // byte_present
  output logic                         m_tlast    // sequence_end
);

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  // Sequence state.
  logic [1:0]             held_count;
  code_t [1:0]            held_symbols;
  logic                   previous_was_n;
  logic [COUNT_BITS-1:0]  collapsed_total;

  logic [1:0]             held_count_next;
  code_t [1:0]            held_symbols_next;
  logic                   previous_was_n_next;
  logic [COUNT_BITS-1:0]  collapsed_total_next;

  logic                   accept;
  code_t                  code;
  logic [SYMBOL_W-1:0]    letter_offset;
  logic                   keep;
  logic                   have_group;
  group_t                 group;
  logic                   emit;
  logic [BYTE_W-1:0]      packed_byte;
  logic [OUT_COUNT_W-1:0] shown_count;

  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;

  // Letters outside 'A'..'T' map to A, which also keeps the table index
  // in range.
  assign letter_offset = s_tdata - LETTER_FIRST;
  always_comb begin
    if (s_tdata < LETTER_FIRST || s_tdata > LETTER_LAST) begin
      code = CODE_A;
    end else begin
      code = LETTER_CODE[letter_offset[TABLE_IDX_W-1:0]];
    end
  end

  // A second N in a row is dropped; every other symbol joins the group.
  assign keep = !(code == CODE_N && previous_was_n);

  always_comb begin
    held_count_next      = held_count;
    held_symbols_next    = held_symbols;
    previous_was_n_next  = previous_was_n;
    collapsed_total_next = collapsed_total;
    have_group           = 1'b0;
    group                = '{default: CODE_A};
    if (keep) begin
      previous_was_n_next = (code == CODE_N);
      if (collapsed_total != COUNT_MAX) begin
        collapsed_total_next = collapsed_total + COUNT_BITS'(1);
      end
      if (held_count >= 2'd2) begin
        group           = '{code, held_symbols[1], held_symbols[0]};
        held_count_next = 2'd0;
        have_group      = 1'b1;
      end else begin
        held_symbols_next[held_count[0]] = code;
        held_count_next = held_count + 2'd1;
      end
    end
    // A partial group at the end of the sequence is padded with A.
    if (s_tlast && !have_group && held_count_next != 2'd0) begin
      group[0]   = held_symbols_next[0];
      group[1]   = (held_count_next >= 2'd2) ? held_symbols_next[1] : CODE_A;
      group[2]   = CODE_A;
      have_group = 1'b1;
    end
  end

  assign emit = have_group || s_tlast;

  dtp_encoder u_encoder (
    .group       (group),
    .packed_byte (packed_byte)
  );

  // The count shown on the bus saturates at 32 bits when the counter is wider.
  generate
    if (COUNT_BITS > OUT_COUNT_W) begin : g_count_wide
      assign shown_count = (|collapsed_total_next[COUNT_BITS-1:OUT_COUNT_W]) ?
                           '1 : collapsed_total_next[OUT_COUNT_W-1:0];
    end else begin : g_count_narrow
      assign shown_count = OUT_COUNT_W'(collapsed_total_next);
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      held_count      <= 2'd0;
      held_symbols    <= '{default: CODE_A};
      previous_was_n  <= 1'b0;
      collapsed_total <= '0;
    end else if (accept) begin
      if (s_tlast) begin
        held_count      <= 2'd0;
        held_symbols    <= '{default: CODE_A};
        previous_was_n  <= 1'b0;
        collapsed_total <= '0;
      end else begin
        held_count      <= held_count_next;
        held_symbols    <= held_symbols_next;
        previous_was_n  <= previous_was_n_next;
        collapsed_total <= collapsed_total_next;
      end
    end
  end

  // Output register: loaded on every transaction that yields a result.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (accept) begin
      m_tvalid <= emit;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && emit) begin
      m_tdata <= {shown_count, have_group ? packed_byte : BYTE_W'(0)};
      m_tuser <= have_group;
      m_tlast <= s_tlast;
    end
  end

  // The group counter never reaches three.
  assert property (@(posedge clk) disable iff (rst) held_count != 2'd3)
    else $error("held_count reached three");

  // A final symbol leaves the sequence state cleared.
  assert property (@(posedge clk) disable iff (rst)
                   accept && s_tlast |=> held_count == 2'd0 && collapsed_total == '0
                                         && !previous_was_n)
    else $error("sequence state not cleared after final symbol");

  // A result only appears after a transaction that produced it.
  assert property (@(posedge clk) disable iff (rst)
                   $rose(m_tvalid) |-> $past(accept))
    else $error("result appeared without an input transaction");

  // A final symbol always produces a result marked as sequence end.
  assert property (@(posedge clk) disable iff (rst)
                   accept && s_tlast |=> m_tvalid && m_tlast)
    else $error("final symbol produced no end result");

endmodule

// ===== src/dtp_encoder.sv =====
// ---------------------------------------------------------------------------
// dtp_encoder: packs one group of three symbol codes into a byte
// Plain codes go to the upper six bits; groups with Ns carry the N count in
// the low bits, and a group with one N also carries the N position there.
// ---------------------------------------------------------------------------
module dtp_encoder
  import dtp_pkg::*;
(
  input  group_t              group,
  output logic [BYTE_W-1:0]   packed_byte
);

  logic [2:0] is_n;
  logic [1:0] n_count;
  logic [1:0] hi;
  logic [1:0] lo;
  logic [1:0] n_pos;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      is_n[i] = (group[i] == CODE_N);
    end
    n_count = 2'($countones(is_n));
    // Codes of the two other positions, higher position first.
    if (is_n[0]) begin
      n_pos = 2'd0;
      hi    = group[2][1:0];
      lo    = group[1][1:0];
    end else if (is_n[1]) begin
      n_pos = 2'd1;
      hi    = group[2][1:0];
      lo    = group[0][1:0];
    end else begin
      n_pos = 2'd2;
      hi    = group[1][1:0];
      lo    = group[0][1:0];
    end
    case (n_count)
      N_NONE:  packed_byte = {group[2][1:0], group[1][1:0], group[0][1:0], N_NONE};
      N_ONE:   packed_byte = {hi, lo, n_pos, N_ONE};
      N_TWO:   packed_byte = {4'd0, group[1][1:0], N_TWO};
      default: packed_byte = {6'd0, N_THREE};
    endcase
  end

endmodule

// ===== verif/dna_triple_packer_tb.sv =====
// ---------------------------------------------------------------------------
// dna_triple_packer_tb: self-checking bench for the DNA triple packer
// Streams ASCII symbols into the packer, predicts every packed byte and end
// marker in a model of its own, and compares each output transaction field
// by field, with random idle gaps on the input and back-pressure on the output.
// ---------------------------------------------------------------------------
module dna_triple_packer_tb;
  import dtp_pkg::*;

  // Nucleotide codes that the package does not name.
  localparam code_t NUC_C = 3'd1;
  localparam code_t NUC_G = 3'd2;
  localparam code_t NUC_T = 3'd3;

  localparam logic [63:0] TOTAL_MAX  = 64'hFFFF_FFFF;  // 2^32 - 1
  localparam int          RAND_ITEMS = 1430;
  localparam int          LONG_HOLD  = 200;
  localparam int          IDLE_LIMIT = 1000;
  localparam int          N_DIRECTED = 21;

  typedef struct packed {
    logic [7:0]  packed_byte;
    logic        present;
    logic        seq_end;
    logic [31:0] count;
  } result_t;

  // One directed row: the symbol, its final flag, and an optional result
  // that is obvious enough to write down by hand.
  typedef struct packed {
    logic [7:0] sym;
    logic       fin;
    logic       typed;
    result_t    res;
  } stim_row_t;

  localparam result_t NO_RES = '0;

  logic                          clk;
  logic                          rst;
  logic                          s_tvalid;
  logic                          s_tready;
  logic [SYMBOL_W-1:0]           s_tdata;   // [7:0] symbol
  logic                          s_tlast;   // final_symbol
  logic                          m_tvalid;
  logic                          m_tready;
  logic [BYTE_W+OUT_COUNT_W-1:0] m_tdata;   // [7:0] packed_byte, [39:8] symbol_count
  logic                          m_tuser;   // byte_present
  logic                          m_tlast;   // sequence_end

  dna_triple_packer dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  // Packer state as the predictor sees it.
  logic [1:0]  held_n;
  code_t       held_c [2];
  bit          after_n;
  logic [63:0] run_total;

  result_t pending_q[$];
  int      err_count   = 0;
  int      symbols_in  = 0;
  int      sequences   = 0;
  int      results_out = 0;
  int      end_markers = 0;
  int      n_groups    = 0;
  int      hold_asked  = 0;
  bit      no_gaps     = 1'b0;

  // Directed rows: single symbol, all-T triple, N runs with N at both ends,
  // a bare end marker after a dropped N, unknown characters and N in the middle.
  stim_row_t directed_rows [N_DIRECTED] = '{
    '{"A",   1'b1, 1'b1, '{8'h00, 1'b1, 1'b1, 32'd1}},
    '{"T",   1'b0, 1'b0, NO_RES},
    '{"T",   1'b0, 1'b0, NO_RES},
    '{"T",   1'b1, 1'b1, '{8'hFC, 1'b1, 1'b1, 32'd3}},
    '{"N",   1'b0, 1'b0, NO_RES},
    '{"N",   1'b0, 1'b0, NO_RES},
    '{"C",   1'b0, 1'b0, NO_RES},
    '{"N",   1'b0, 1'b0, NO_RES},
    '{"G",   1'b1, 1'b0, NO_RES},
    '{"A",   1'b0, 1'b0, NO_RES},
    '{"C",   1'b0, 1'b0, NO_RES},
    '{"N",   1'b0, 1'b0, NO_RES},
    '{"N",   1'b1, 1'b1, '{8'h00, 1'b0, 1'b1, 32'd3}},
    '{8'h00, 1'b0, 1'b0, NO_RES},
    '{8'hFF, 1'b0, 1'b0, NO_RES},
    '{8'h40, 1'b0, 1'b0, NO_RES},
    '{"B",   1'b0, 1'b0, NO_RES},
    '{8'h55, 1'b1, 1'b0, NO_RES},
    '{"G",   1'b0, 1'b0, NO_RES},
    '{"N",   1'b0, 1'b0, NO_RES},
    '{"T",   1'b1, 1'b0, NO_RES}
  };

  function automatic code_t symbol_code(input logic [7:0] ch);
    case (ch)
      "C":     return NUC_C;
      "G":     return NUC_G;
      "T":     return NUC_T;
      "N":     return CODE_N;
      default: return CODE_A;
    endcase
  endfunction

  // Bits 1:0 carry the N count; the N position sits in bits 3:2 when there
  // is exactly one, with the two other codes above it, higher position first.
  function automatic logic [7:0] encode_triple(input code_t c0, input code_t c1,
                                               input code_t c2);
    int         n_cnt;
    logic [1:0] n_pos;
    logic [1:0] hi;
    logic [1:0] lo;
    n_cnt = int'(c0 == CODE_N) + int'(c1 == CODE_N) + int'(c2 == CODE_N);
    n_pos = (c2 == CODE_N) ? 2'd2 : (c1 == CODE_N) ? 2'd1 : 2'd0;
    case (n_cnt)
      0: return {c2[1:0], c1[1:0], c0[1:0], N_NONE};
      1: begin
        hi = (n_pos == 2'd2) ? c1[1:0] : c2[1:0];
        lo = (n_pos == 2'd0) ? c1[1:0] : c0[1:0];
        return {hi, lo, n_pos, N_ONE};
      end
      2: return {4'd0, c1[1:0], N_TWO};
      default: return {6'd0, N_THREE};
    endcase
  endfunction

  function automatic bit predict_packer(input logic [7:0] sym, input logic fin,
                                        output result_t r);
    code_t c;
    code_t trip [3];
    bit    full;
    c    = symbol_code(sym);
    full = 1'b0;
    trip = '{CODE_A, CODE_A, CODE_A};
    r    = '0;
    // A repeated N is dropped entirely: no count, no slot.
    if (!(c == CODE_N && after_n)) begin
      after_n = (c == CODE_N);
      if (run_total < TOTAL_MAX) run_total++;
      if (held_n == 2'd2) begin
        trip   = '{held_c[0], held_c[1], c};
        held_n = 2'd0;
        full   = 1'b1;
      end else begin
        held_c[held_n[0]] = c;
        held_n++;
      end
    end
    // Partial triple at the end of a sequence is padded with A.
    if (fin && !full && held_n != 2'd0) begin
      trip[0] = held_c[0];
      trip[1] = (held_n == 2'd2) ? held_c[1] : CODE_A;
      trip[2] = CODE_A;
      full    = 1'b1;
    end
    if (!full && !fin) return 1'b0;
    r.packed_byte = full ? encode_triple(trip[0], trip[1], trip[2]) : 8'h00;
    r.present     = full;
    r.seq_end     = fin;
    r.count       = (run_total > TOTAL_MAX) ? 32'hFFFF_FFFF : run_total[31:0];
    if (fin) clear_packer();
    return 1'b1;
  endfunction

  function automatic void clear_packer();
    held_n    = 2'd0;
    held_c[0] = CODE_A;
    held_c[1] = CODE_A;
    after_n   = 1'b0;
    run_total = '0;
  endfunction

  function automatic int pick_gap();
    int coin;
    coin = $urandom_range(0, 99);
    if (no_gaps || coin < 60) return 0;
    if (coin < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (err_count < 20)
      $display("mismatch: %s got 0x%0h expected 0x%0h at %0t", what, got, want, $time);
    err_count++;
  endtask

  // Called right after a rising edge; returns right after the edge at which
  // the symbol was taken, with s_tvalid still high.
  task automatic push_symbol(input logic [7:0] sym, input logic fin,
                             input bit typed, input result_t typed_res);
    int      gap;
    result_t r;
    bit      has;
    gap = pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= sym;
    s_tlast  <= fin;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    has = predict_packer(sym, fin, r);
    if (typed) r = typed_res;
    if (has || typed) pending_q.insert(pending_q.size(), r);
    symbols_in++;
    if (fin) sequences++;
  endtask

  task automatic drain_results();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_q.size() != 0) @(posedge clk);
  endtask

  // Checker on the output stream.
  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (!rst && m_tvalid && m_tready) begin
      got = '{m_tdata[7:0], m_tuser, m_tlast, m_tdata[39:8]};
      results_out++;
      if (got.present && got.packed_byte[1:0] != N_NONE) n_groups++;
      if (!got.present) end_markers++;
      if (pending_q.size() == 0) begin
        report_mismatch("result with nothing pending, packed_byte",
                        32'(got.packed_byte), 32'd0);
      end else begin
        want = pending_q.pop_front();
        if (got.packed_byte != want.packed_byte)
          report_mismatch("packed_byte", 32'(got.packed_byte), 32'(want.packed_byte));
        if (got.present != want.present)
          report_mismatch("byte_present", 32'(got.present), 32'(want.present));
        if (got.seq_end != want.seq_end)
          report_mismatch("sequence_end", 32'(got.seq_end), 32'(want.seq_end));
        if (got.count != want.count)
          report_mismatch("symbol_count", got.count, want.count);
      end
    end
  end

  // Receiver: random back-pressure, free-running stretches, and a long
  // hold-off whenever the sender asks for one.
  initial begin : sink
    int hold_done;
    int stall_left;
    int mode_left;
    int coin;
    bit free_run;
    hold_done  = 0;
    stall_left = 0;
    mode_left  = 0;
    free_run   = 1'b0;
    m_tready   = 1'b0;
    forever begin
      @(posedge clk);
      if (mode_left == 0) begin
        free_run  = ($urandom_range(0, 3) == 0);
        mode_left = 64;
      end
      mode_left--;
      if (hold_done < hold_asked) begin
        hold_done++;
        m_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else if (stall_left > 0) begin
        stall_left--;
        m_tready <= 1'b0;
      end else begin
        coin = $urandom_range(0, 99);
        if (!free_run && coin < 25) begin
          stall_left = (coin < 2) ? $urandom_range(10, 40) : $urandom_range(0, 3);
          m_tready <= 1'b0;
        end else begin
          m_tready <= 1'b1;
        end
      end
    end
  end

  // Watchdog on progress: any cycle without a transaction on either side
  // counts toward the limit.
  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle = 0;
      else idle++;
    end
    $display("timeout: no transaction for %0d cycles", IDLE_LIMIT);
    $display("status: fail");
    $finish;
  end

  initial begin : source
    int    sent;
    int    len;
    int    k;
    int    coin;
    bit    noise;
    bit    in_n_run;
    bit    fin;
    logic [7:0] sym;
    rst      = 1'b1;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    s_tlast  = 1'b0;
    clear_packer();
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < N_DIRECTED; i++)
      push_symbol(directed_rows[i].sym, directed_rows[i].fin,
                  directed_rows[i].typed, directed_rows[i].res);
    drain_results();

    // Random sequences: mostly nucleotides with N runs, some noise bytes,
    // a few sequences made of raw bytes with stray final flags.
    sent = 0;
    while (sent < RAND_ITEMS) begin
      len      = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 10);
      noise    = ($urandom_range(0, 9) == 0);
      no_gaps  = ($urandom_range(0, 4) == 0);
      in_n_run = 1'b0;
      for (k = 0; k < len; k++) begin
        coin = $urandom_range(0, 99);
        if (noise || coin < 8) begin
          sym = 8'($urandom_range(0, 255));
        end else if (in_n_run && coin < 55) begin
          sym = "N";
        end else begin
          case ($urandom_range(0, 4))
            0:       sym = "A";
            1:       sym = "C";
            2:       sym = "G";
            3:       sym = "T";
            default: sym = "N";
          endcase
        end
        in_n_run = (sym == "N");
        fin = (k == len - 1) || (noise && $urandom_range(0, 3) == 0);
        push_symbol(sym, fin, 1'b0, NO_RES);
        sent++;
        if (sent == 400 || sent == 1000) hold_asked++;
        if (sent == 700) drain_results();
      end
    end
    no_gaps = 1'b0;

    drain_results();
    repeat (4) @(posedge clk);
    $display("covered %0d symbols in %0d sequences; %0d results checked,", symbols_in,
             sequences, results_out);
    $display("  %0d of them end markers without a byte and %0d triples with an N",
             end_markers, n_groups);
    if (err_count == 0) begin
      $display("status: pass");
    end else begin
      $display("%0d mismatches", err_count);
      $display("status: fail");
    end
    $finish;
  end

endmodule
